>>> design/assert_macros.svh
// Assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: implication");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> design/sqll_pkg.sv
// ----------------------------------------------------------------------------
// sqll_pkg
// Shared types, constants and character classes of the SQL lexer.
// ----------------------------------------------------------------------------
package sqll_pkg;

   localparam int OFFSET_BITS  = 16;
   localparam int NUM_KEYWORDS = 45;
   localparam int FIFO_DEPTH   = 8;
   localparam int PTR_BITS     = $clog2(FIFO_DEPTH);

   typedef logic [OFFSET_BITS-1:0] off_type;
   localparam off_type OFFSET_MAX = '1;

   localparam logic [4:0] KIND_IDENT   = 5'd0;
   localparam logic [4:0] KIND_KEYWORD = 5'd1;
   localparam logic [4:0] KIND_INT     = 5'd2;
   localparam logic [4:0] KIND_FLOAT   = 5'd3;
   localparam logic [4:0] KIND_STRING  = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd5;
   localparam logic [4:0] KIND_MINUS   = 5'd6;
   localparam logic [4:0] KIND_STAR    = 5'd7;
   localparam logic [4:0] KIND_SLASH   = 5'd8;
   localparam logic [4:0] KIND_SEMI    = 5'd9;
   localparam logic [4:0] KIND_COMMA   = 5'd10;
   localparam logic [4:0] KIND_GT      = 5'd11;
   localparam logic [4:0] KIND_LT      = 5'd12;
   localparam logic [4:0] KIND_LPAREN  = 5'd13;
   localparam logic [4:0] KIND_RPAREN  = 5'd14;
   localparam logic [4:0] KIND_EQ      = 5'd15;
   localparam logic [4:0] KIND_GE      = 5'd16;
   localparam logic [4:0] KIND_LE      = 5'd17;
   localparam logic [4:0] KIND_NE      = 5'd18;
   localparam logic [4:0] KIND_ILLEGAL = 5'd19;
   localparam logic [4:0] KIND_END     = 5'd20;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Keywords packed first byte lowest (literals are written reversed)
   localparam logic [63:0] KW_WORDS [NUM_KEYWORDS] = '{
      64'("dda"), 64'("retla"), 64'("lla"), 64'("dna"), 64'("yna"), 64'("sa"),
      64'("csa"), 64'("gva"), 64'("yb"), 64'("kcehc"), 64'("nmuloc"),
      64'("tnuoc"), 64'("etaerc"), 64'("eteled"), 64'("csed"), 64'("pord"),
      64'("tcnitsid"), 64'("tpecxe"), 64'("ngierof"), 64'("morf"),
      64'("puorg"), 64'("gnivah"), 64'("ni"), 64'("xedni"), 64'("si"),
      64'("tresni"), 64'("otni"), 64'("nioj"), 64'("yek"), 64'("ekil"),
      64'("nim"), 64'("xam"), 64'("ton"), 64'("llun"), 64'("ro"),
      64'("redro"), 64'("yramirp"), 64'("elbat"), 64'("tceles"), 64'("tes"),
      64'("mus"), 64'("etadpu"), 64'("noinu"), 64'("seulav"), 64'("erehw")
   };

   typedef struct packed {
      logic [4:0]  kind;
      logic [5:0]  kw;
      logic [15:0] start;
      logic [15:0] len;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    t0;
      tok_type    t1;
   } step_type;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'd9 || c == 8'd10 || c == 8'd32;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c >= 8'd33 && c <= 8'd126 && !is_digit(c) && !is_alpha(c);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

   function automatic off_type sat_inc(input off_type v);
      return (v == OFFSET_MAX) ? v : v + off_type'(1);
   endfunction

   function automatic logic [4:0] single_op_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h3B:   k = KIND_SEMI;
         8'h2C:   k = KIND_COMMA;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         default: k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage

>>> design/sqll_keyword_match.sv
// ----------------------------------------------------------------------------
// sqll_keyword_match
// Parallel compare of the buffered word against the keyword list.
// ----------------------------------------------------------------------------
module sqll_keyword_match import sqll_pkg::*; (
   input  logic [63:0] word,
   input  logic        too_long,
   output logic [5:0]  kw_index
);

   // OR together the one matching index (keywords are distinct)
   always_comb begin
      kw_index = '0;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (!too_long && word == KW_WORDS[i]) begin
            kw_index = kw_index | 6'(i + 1);
         end
      end
   end

endmodule

>>> design/sqll_lex_core.sv
// ----------------------------------------------------------------------------
// sqll_lex_core
// Lexer state and the combinational update for one registered transaction.
// ----------------------------------------------------------------------------
module sqll_lex_core import sqll_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  logic       item_opcode,
   input  logic [7:0] item_byte,
   output step_type   step
);

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_NUMBER = 5'b00010,
      MODE_WORD   = 5'b00100,
      MODE_STRING = 5'b01000,
      MODE_PUNCT  = 5'b10000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [63:0] word_ff, word_in;
   logic        too_long_ff, too_long_in;
   logic [1:0]  dots_ff, dots_in;
   logic        quote_ff, quote_in;
   logic [15:0] pair_ff, pair_in;
   off_type     pos_ff, pos_in;
   off_type     begin_ff, begin_in;
   off_type     run_ff, run_in;

   logic [5:0]  kw_index;
   tok_type     close_tok, start_tok, tok_a, tok_b;
   logic        st_emit, use_a, use_b, do_close, do_start;
   mode_type    st_mode;
   logic        st_quote;
   off_type     st_begin, st_run;
   logic [7:0]  c;

   sqll_keyword_match u_kw (
      .word     (word_ff),
      .too_long (too_long_ff),
      .kw_index (kw_index)
   );

   assign c = item_byte;

   // Build the token that closes the open run
   always_comb begin
      close_tok       = '0;
      close_tok.start = 16'(begin_ff);
      close_tok.len   = 16'(run_ff);
      case (mode_ff)
         MODE_NUMBER: begin
            close_tok.kind = (dots_ff == 2'd0) ? KIND_INT :
                             (dots_ff == 2'd1) ? KIND_FLOAT : KIND_ILLEGAL;
         end
         MODE_WORD: begin
            close_tok.kind = (kw_index != 6'd0) ? KIND_KEYWORD : KIND_IDENT;
            close_tok.kw   = kw_index;
         end
         MODE_PUNCT: begin
            close_tok.kind = KIND_ILLEGAL;
            if (run_ff == off_type'(1)) begin
               if (pair_ff[7:0] == 8'h3E) close_tok.kind = KIND_GT;
               else if (pair_ff[7:0] == 8'h3C) close_tok.kind = KIND_LT;
               else if (pair_ff[7:0] == 8'h3D) close_tok.kind = KIND_EQ;
            end else if (run_ff == off_type'(2)) begin
               if (pair_ff == 16'h3D3E) close_tok.kind = KIND_GE;
               else if (pair_ff == 16'h3D3C) close_tok.kind = KIND_LE;
               else if (pair_ff == 16'h3D21 || pair_ff == 16'h3E3C) close_tok.kind = KIND_NE;
            end
         end
         default: close_tok.kind = KIND_ILLEGAL;
      endcase
   end

   // Classify the byte as the first byte of a new token
   always_comb begin
      st_emit         = 1'b0;
      start_tok       = '0;
      start_tok.start = 16'(pos_ff);
      start_tok.len   = 16'd1;
      st_mode         = MODE_IDLE;
      st_quote        = quote_ff;
      st_begin        = pos_ff;
      st_run          = off_type'(1);
      if (is_blank(c)) begin
         st_begin = begin_ff;
         st_run   = run_ff;
      end else if (c == 8'h22 || c == 8'h27) begin
         st_mode  = MODE_STRING;
         st_quote = (c == 8'h27);
         st_begin = sat_inc(pos_ff);
         st_run   = '0;
      end else if (is_digit(c)) begin
         st_mode = MODE_NUMBER;
      end else if (is_alpha(c)) begin
         st_mode = MODE_WORD;
      end else if (is_punct(c) && single_op_kind(c) != KIND_IDENT) begin
         st_emit        = 1'b1;
         start_tok.kind = single_op_kind(c);
         st_begin       = begin_ff;
         st_run         = run_ff;
      end else if (is_punct(c)) begin
         st_mode = MODE_PUNCT;
      end else begin
         st_emit        = 1'b1;
         start_tok.kind = KIND_ILLEGAL;
         st_begin       = begin_ff;
         st_run         = run_ff;
      end
   end

   // Advance the mode and collect up to two transactions
   always_comb begin
      mode_in     = mode_ff;
      word_in     = word_ff;
      too_long_in = too_long_ff;
      dots_in     = dots_ff;
      quote_in    = quote_ff;
      pair_in     = pair_ff;
      pos_in      = pos_ff;
      begin_in    = begin_ff;
      run_in      = run_ff;
      do_close    = 1'b0;
      do_start    = 1'b0;
      use_a       = 1'b0;
      use_b       = 1'b0;
      tok_a       = close_tok;
      tok_b       = start_tok;

      if (item_opcode == OP_END) begin
         use_a       = (mode_ff != MODE_IDLE);
         use_b       = 1'b1;
         tok_b       = '0;
         tok_b.kind  = KIND_END;
         tok_b.start = 16'(pos_ff);
         mode_in     = MODE_IDLE;
         word_in     = '0;
         too_long_in = 1'b0;
         dots_in     = '0;
         quote_in    = 1'b0;
         pair_in     = '0;
         pos_in      = '0;
         begin_in    = '0;
         run_in      = '0;
      end else begin
         pos_in = sat_inc(pos_ff);
         case (mode_ff)
            MODE_NUMBER: begin
               if (is_digit(c) || c == 8'h2E) begin
                  run_in = sat_inc(run_ff);
                  if (c == 8'h2E && dots_ff != 2'd2) dots_in = dots_ff + 2'd1;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(c) || c == 8'h5F) begin
                  if (run_ff < off_type'(8)) begin
                     for (int l = 0; l < 8; l++) begin
                        if (run_ff[2:0] == 3'(l)) word_in[8*l +: 8] = to_lower(c);
                     end
                  end else begin
                     too_long_in = 1'b1;
                  end
                  run_in = sat_inc(run_ff);
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == (quote_ff ? 8'h27 : 8'h22)) begin
                  use_a          = 1'b1;
                  tok_a.kind     = KIND_STRING;
                  tok_a.kw       = '0;
                  mode_in        = MODE_IDLE;
               end else begin
                  run_in = sat_inc(run_ff);
               end
            end
            MODE_PUNCT: begin
               if (is_punct(c)) begin
                  if (run_ff == off_type'(1)) pair_in = {c, pair_ff[7:0]};
                  run_in = sat_inc(run_ff);
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase

         if (do_close) begin
            use_a   = 1'b1;
            mode_in = MODE_IDLE;
         end
         if (do_start) begin
            use_b    = st_emit;
            mode_in  = st_mode;
            quote_in = st_quote;
            begin_in = st_begin;
            run_in   = st_run;
            if (st_mode == MODE_NUMBER) dots_in = '0;
            if (st_mode == MODE_WORD) begin
               word_in     = {56'd0, to_lower(c)};
               too_long_in = 1'b0;
            end
            if (st_mode == MODE_PUNCT) pair_in = {8'd0, c};
         end
      end
   end

   // Pack results in order, flag the final one
   always_comb begin
      step       = '0;
      step.count = 2'(use_a) + 2'(use_b);
      step.t0    = use_a ? tok_a : tok_b;
      step.t1    = tok_b;
      step.t0.last = (step.count == 2'd1);
      step.t1.last = 1'b1;
      if (!item_valid) step.count = 2'd0;
   end

   // Hold state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         word_ff     <= '0;
         too_long_ff <= 1'b0;
         dots_ff     <= '0;
         quote_ff    <= 1'b0;
         pair_ff     <= '0;
         pos_ff      <= '0;
         begin_ff    <= '0;
         run_ff      <= '0;
      end else if (item_valid) begin
         mode_ff     <= mode_in;
         word_ff     <= word_in;
         too_long_ff <= too_long_in;
         dots_ff     <= dots_in;
         quote_ff    <= quote_in;
         pair_ff     <= pair_in;
         pos_ff      <= pos_in;
         begin_ff    <= begin_in;
         run_ff      <= run_in;
      end
   end

endmodule

>>> design/sqll_rsp_fifo.sv
// ----------------------------------------------------------------------------
// sqll_rsp_fifo
// Result queue: takes up to two tokens per cycle, hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module sqll_rsp_fifo import sqll_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  step_type          step,
   input  logic              pop,
   output logic              not_empty,
   output tok_type           head,
   output logic [PTR_BITS:0] fill
);

   tok_type             mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_pop;

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rptr_ff];
   assign fill      = count_ff;
   assign do_pop    = pop && not_empty;

   // Advance pointers and fill level
   always_comb begin
      wptr_in  = wptr_ff + PTR_BITS'(step.count);
      rptr_in  = rptr_ff + PTR_BITS'(do_pop);
      count_in = count_ff + (PTR_BITS+1)'(step.count) - (PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Write the new tokens
   always_ff @(posedge clock) begin
      if (step.count != 2'd0) mem_ff[wptr_ff] <= step.t0;
      if (step.count == 2'd2) mem_ff[wptr_ff + PTR_BITS'(1)] <= step.t1;
   end

endmodule

>>> design/sql_lexer_stream_unit.sv
// ----------------------------------------------------------------------------
// sql_lexer_stream_unit
// Streaming SQL lexer: one text byte per transaction in, token descriptors out.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   req_valid/stall    opcode, char_byte
// rsp      out  rsp_valid/stall    token_kind, keyword_index, token_start,
//                                  token_length, last_of_step
//
// One byte per cycle sustained while req_stall stays low; the results of a byte enter
// the result queue in the cycle after acceptance (input register, then the lexer update).
// Each byte yields zero, one or two results into an eight-entry queue;
// req_stall rises when the queue cannot take two more results per item held.
// Synchronous reset returns the lexer to offset 0 and empties the queue.
// ----------------------------------------------------------------------------
module sql_lexer_stream_unit import sqll_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [5:0]  rsp_keyword_index,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_step
);

   logic              stage_valid_ff, stage_valid_in;
   logic              stage_opcode_ff;
   logic [7:0]        stage_byte_ff;
   logic              req_take;
   logic [PTR_BITS:0] fill;
   logic [PTR_BITS+1:0] need;
   step_type          step;
   tok_type           head;

   // Reserve two queue slots per transaction in flight
   assign need      = stage_valid_ff ? (PTR_BITS+2)'(4) : (PTR_BITS+2)'(2);
   assign req_stall = ((PTR_BITS+2)'(fill) + need) > (PTR_BITS+2)'(FIFO_DEPTH);
   assign req_take  = req_valid && !req_stall;
   assign stage_valid_in = req_take;

   // Register the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) stage_valid_ff <= 1'b0;
      else       stage_valid_ff <= stage_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_opcode_ff <= req_opcode;
         stage_byte_ff   <= req_char_byte;
      end
   end

   sqll_lex_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (stage_valid_ff),
      .item_opcode (stage_opcode_ff),
      .item_byte   (stage_byte_ff),
      .step        (step)
   );

   sqll_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pop       (!rsp_stall),
      .not_empty (rsp_valid),
      .head      (head),
      .fill      (fill)
   );

   assign rsp_token_kind    = head.kind;
   assign rsp_keyword_index = head.kw;
   assign rsp_token_start   = head.start;
   assign rsp_token_length  = head.len;
   assign rsp_last_of_step  = head.last;

endmodule

>>> design/sqll_checker.sv
// ----------------------------------------------------------------------------
// sqll_checker
// Port-level checks of the SQL lexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sqll_checker import sqll_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_token_kind,
   input logic [5:0]  rsp_keyword_index,
   input logic [15:0] rsp_token_length,
   input logic        rsp_last_of_step
);

   // Queue empties on reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   // A stalled result transaction stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // End token has no text and closes its step
   `ASSERT_IMPLY(a_end_shape, clock, reset, rsp_valid && rsp_token_kind == KIND_END, rsp_token_length == 16'd0 && rsp_last_of_step)
   // Only keywords carry an index
   `ASSERT_IMPLY(a_kw_only, clock, reset, rsp_valid && rsp_token_kind != KIND_KEYWORD, rsp_keyword_index == 6'd0)

endmodule

bind sql_lexer_stream_unit sqll_checker u_sqll_checker (.*);
